FILE: src/windowed_sound_level_stats_defines.svh
// assertion macros for the sound level meter
`ifndef WINDOWED_SOUND_LEVEL_STATS_DEFINES_SVH
`define WINDOWED_SOUND_LEVEL_STATS_DEFINES_SVH

// implication checked on every clock edge outside reset
`define WSLS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequence is checked in the following cycle
`define WSLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/wsls_pkg.sv
// ----------------------------------------------------------------------------
// wsls_pkg
// shared widths and the window summary passed from front to back end
// ----------------------------------------------------------------------------
`default_nettype none
package wsls_pkg;
  localparam int SampleBits = 12;
  localparam int CountBits  = 24;
  localparam int SumBits    = CountBits + SampleBits;
  localparam int SqBits     = CountBits + 2 * SampleBits;
  localparam int ProdBits   = CountBits + SqBits;
  localparam int RadBits    = ProdBits + 8;
  localparam int RootBits   = RadBits / 2;
  localparam int QueueDepth = 2;
  localparam logic [15:0] TotalSat = 16'hFFFF;

  // closed window summary
  typedef struct packed {
    logic [CountBits-1:0]  cnt;
    logic [SumBits-1:0]    sum;
    logic [SqBits-1:0]     sumsq;
    logic [SampleBits-1:0] mn;
    logic [SampleBits-1:0] mx;
    logic                  drop;
  } win_t;
endpackage
`default_nettype wire

FILE: src/wsls_front.sv
// ----------------------------------------------------------------------------
// wsls_front
// accumulates samples and pushes a window summary on window end
// ----------------------------------------------------------------------------
`default_nettype none
module wsls_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [wsls_pkg::SampleBits-1:0]    sample_mv_i,
  input  wire logic                               sample_valid_i,
  input  wire logic                               window_end_i,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  output      logic                               push_o,
  output      wsls_pkg::win_t                     win_o,
  input  wire logic                               full_i
);
  localparam logic [wsls_pkg::CountBits-1:0] Lim = '1;
  wsls_pkg::win_t acc_q, acc_d, clr;
  logic take;

  assign in_ready_o = !full_i;
  assign take = in_valid_i && in_ready_o;

  // reset value of the accumulator
  always_comb begin
    clr = '0;
    clr.mn = '1;
  end

  // add one sample, or flag a drop once the count is at its limit
  always_comb begin
    acc_d = acc_q;
    if (sample_valid_i) begin
      if (acc_q.cnt == Lim) begin
        acc_d.drop = 1'b1;
      end else begin
        acc_d.cnt = acc_q.cnt + 1'b1;
        acc_d.sum = acc_q.sum + wsls_pkg::SumBits'(sample_mv_i);
        acc_d.sumsq = acc_q.sumsq +
                      wsls_pkg::SqBits'(sample_mv_i) * wsls_pkg::SqBits'(sample_mv_i);
        if (sample_mv_i < acc_q.mn) acc_d.mn = sample_mv_i;
        if (sample_mv_i > acc_q.mx) acc_d.mx = sample_mv_i;
      end
    end
  end

  assign push_o = take && window_end_i;
  assign win_o  = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= clr;
    end else if (take) begin
      acc_q <= window_end_i ? clr : acc_d;
    end
  end
endmodule
`default_nettype wire

FILE: src/wsls_queue.sv
// ----------------------------------------------------------------------------
// wsls_queue
// small fifo of closed window summaries
// ----------------------------------------------------------------------------
`default_nettype none
module wsls_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wsls_pkg::win_t data_i,
  output      logic           full_o,
  output      logic           nempty_o,
  input  wire logic           pop_i,
  output      wsls_pkg::win_t data_o
);
  localparam int AW = $clog2(wsls_pkg::QueueDepth);
  wsls_pkg::win_t mem_q [wsls_pkg::QueueDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o   = cnt_q == (AW+1)'(wsls_pkg::QueueDepth);
  assign nempty_o = cnt_q != '0;
  assign data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers wrap at the power of two depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

FILE: src/wsls_back.sv
// ----------------------------------------------------------------------------
// wsls_back
// sequencer computing dc, rms and peak with shared serial divider and root
// ----------------------------------------------------------------------------
`default_nettype none
module wsls_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           nempty_i,
  input  wire wsls_pkg::win_t win_i,
  output      logic           pop_o,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      logic [15:0]    dc_level_o,
  output      logic [14:0]    rms_level_o,
  output      logic [15:0]    peak_level_o,
  output      logic [15:0]    sample_total_o,
  output      logic           count_overflow_o,
  output      logic           window_empty_o
);
  localparam int CB = wsls_pkg::CountBits;
  localparam int SB = wsls_pkg::SumBits;
  localparam int QB = wsls_pkg::SqBits;
  localparam int PB = wsls_pkg::ProdBits;
  localparam int RB = wsls_pkg::RadBits;
  localparam int TB = wsls_pkg::RootBits;
  localparam int DB = (SB + 4 > TB) ? SB + 4 : TB;   // dividend width
  localparam int KB = $clog2(DB + RB + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MA, S_MB, S_DIFF, S_SQRT, S_DIV_DC, S_DIV_RMS, S_PEAK, S_OUT
  } st_e;

  st_e st_q;
  wsls_pkg::win_t w_q;
  // serial multiplier: shift-add one bit per cycle
  logic [PB-1:0] pa_q, pb_q;   // products n*sumsq and sum^2
  logic [PB-1:0] macc_q;
  logic [PB-1:0] mcand_q;
  logic [QB-1:0] mplier_q;
  logic [RB-1:0] rad_q;        // radicand, consumed two bits per step
  logic [TB-1:0] root_q;
  logic [TB+1:0] rem_q;
  logic [DB-1:0] quo_q;        // dividend then quotient
  logic [CB:0]   drem_q;
  logic [KB-1:0] k_q;
  logic [DB-1:0] dc_q;
  logic [TB+1:0] trial;
  logic [CB:0]   dtrial;
  logic [16:0]   up, dn;

  assign trial  = {rem_q[TB-1:0], rad_q[RB-1 -: 2]} - {root_q, 2'b01};
  assign dtrial = {drem_q[CB-1:0], quo_q[DB-1]} - {1'b0, w_q.cnt};
  assign pop_o  = (st_q == S_IDLE) && nempty_i;
  assign up = ({1'b0, w_q.mx, 4'b0} > 17'(dc_q)) ? {1'b0, w_q.mx, 4'b0} - 17'(dc_q) : '0;
  assign dn = (17'(dc_q) > {1'b0, w_q.mn, 4'b0}) ? 17'(dc_q) - {1'b0, w_q.mn, 4'b0} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      out_valid_o <= 1'b0;
      w_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      macc_q <= '0;
      mcand_q <= '0;
      mplier_q <= '0;
      rad_q <= '0;
      root_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      drem_q <= '0;
      k_q <= '0;
      dc_q <= '0;
      dc_level_o <= '0;
      rms_level_o <= '0;
      peak_level_o <= '0;
      sample_total_o <= '0;
      count_overflow_o <= 1'b0;
      window_empty_o <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: begin
          if (nempty_i) begin
            w_q <= win_i;
            macc_q <= '0;
            mcand_q <= PB'(win_i.cnt);
            mplier_q <= win_i.sumsq;
            k_q <= KB'(QB);
            st_q <= S_MA;
          end
        end
        S_MA: begin
          if (mplier_q[0]) macc_q <= macc_q + mcand_q;
          mcand_q <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          k_q <= k_q - 1'b1;
          if (k_q == KB'(1)) begin
            pa_q <= mplier_q[0] ? macc_q + mcand_q : macc_q;
            macc_q <= '0;
            mcand_q <= PB'(w_q.sum);
            mplier_q <= QB'(w_q.sum);
            k_q <= KB'(SB);
            st_q <= S_MB;
          end
        end
        S_MB: begin
          if (mplier_q[0]) macc_q <= macc_q + mcand_q;
          mcand_q <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          k_q <= k_q - 1'b1;
          if (k_q == KB'(1)) begin
            pb_q <= mplier_q[0] ? macc_q + mcand_q : macc_q;
            st_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          rad_q <= (pa_q > pb_q) ? {pa_q - pb_q, 8'h00} : '0;
          root_q <= '0;
          rem_q <= '0;
          k_q <= KB'(TB);
          st_q <= S_SQRT;
        end
        // restoring square root, two radicand bits per step
        S_SQRT: begin
          rad_q <= rad_q << 2;
          k_q <= k_q - 1'b1;
          if (!trial[TB+1]) begin
            rem_q <= trial;
            root_q <= {root_q[TB-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[TB-1:0], rad_q[RB-1 -: 2]};
            root_q <= {root_q[TB-2:0], 1'b0};
          end
          if (k_q == KB'(1)) begin
            quo_q <= DB'({w_q.sum, 4'b0});
            drem_q <= '0;
            k_q <= KB'(DB);
            st_q <= S_DIV_DC;
          end
        end
        // restoring division by the sample count, one bit per step
        S_DIV_DC, S_DIV_RMS: begin
          k_q <= k_q - 1'b1;
          if (!dtrial[CB]) begin
            drem_q <= dtrial;
            quo_q <= {quo_q[DB-2:0], 1'b1};
          end else begin
            drem_q <= {drem_q[CB-1:0], quo_q[DB-1]};
            quo_q <= {quo_q[DB-2:0], 1'b0};
          end
          if (k_q == KB'(1)) begin
            if (st_q == S_DIV_DC) begin
              dc_q <= {quo_q[DB-2:0], !dtrial[CB]};
              quo_q <= DB'(root_q);
              drem_q <= '0;
              k_q <= KB'(DB);
              st_q <= S_DIV_RMS;
            end else begin
              st_q <= S_PEAK;
            end
          end
        end
        S_PEAK: begin
          out_valid_o <= 1'b1;
          window_empty_o <= w_q.cnt == '0;
          if (w_q.cnt == '0) begin
            dc_level_o <= '0;
            rms_level_o <= '0;
            peak_level_o <= '0;
            sample_total_o <= '0;
            count_overflow_o <= 1'b0;
          end else begin
            dc_level_o <= dc_q[15:0];
            rms_level_o <= quo_q[14:0];
            peak_level_o <= (up > dn) ? up[15:0] : dn[15:0];
            sample_total_o <= (w_q.cnt > CB'(wsls_pkg::TotalSat)) ?
                              wsls_pkg::TotalSat : w_q.cnt[15:0];
            count_overflow_o <= w_q.drop;
          end
          st_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/windowed_sound_level_stats.sv
// flow: the back end runs the serial multiplier, root and divider for one window at a time
// and takes the next window from the queue only after its result is accepted
// throughput: one sample transaction per cycle while in_ready_o is high;
// input stalls only while two closed windows wait behind a busy back end
// reset: asynchronous active low, clears accumulators (min to all ones) and queue
// ----------------------------------------------------------------------------
// windowed_sound_level_stats
// windowed dc, rms and peak meter: accumulator front end, math back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_sound_level_stats_defines.svh"
module windowed_sound_level_stats (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [11:0] sample_mv_i,
  input  wire logic        sample_valid_i,
  input  wire logic        window_end_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [15:0] dc_level_o,
  output      logic [14:0] rms_level_o,
  output      logic [15:0] peak_level_o,
  output      logic [15:0] sample_total_o,
  output      logic        count_overflow_o,
  output      logic        window_empty_o
);
  logic push, full, nempty, pop;
  wsls_pkg::win_t win_in, win_out;

  wsls_front u_front (
    .clk_i, .rst_ni, .sample_mv_i, .sample_valid_i, .window_end_i, .in_valid_i,
    .in_ready_o, .push_o(push), .win_o(win_in), .full_i(full)
  );

  wsls_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(win_in), .full_o(full),
    .nempty_o(nempty), .pop_i(pop), .data_o(win_out)
  );

  wsls_back u_back (
    .clk_i, .rst_ni, .nempty_i(nempty), .win_i(win_out), .pop_o(pop),
    .out_valid_o, .out_ready_i, .dc_level_o, .rms_level_o, .peak_level_o,
    .sample_total_o, .count_overflow_o, .window_empty_o
  );

  // transaction checks
  `WSLS_ASSERT(a_no_push_full, full, !push)
  `WSLS_ASSERT(a_empty_zero, out_valid_o && window_empty_o, dc_level_o == '0 && sample_total_o == '0)
  `WSLS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(dc_level_o))
endmodule
`default_nettype wire
